// ===== rtl/core/tfar_pkg.sv =====
// ----------------------------------------------------------------------------
// tfar_pkg
// shared types and constants of the thermal frame auto-range block
// ----------------------------------------------------------------------------
package tfar_pkg;

	localparam int WINDOW_DEPTH_DEF = 256;
	localparam int MAX_DIM_DEF      = 1024;

	localparam int PIX_W     = 16;
	localparam int HIGH_W    = 17;
	localparam int SUM_W     = 36;
	localparam int CNT_W     = 21;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;
	localparam int FDIM_W    = 11;
	localparam int ROI_W     = 16;
	localparam int WLEN_W    = 9;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 128;

	localparam logic [FDIM_W-1:0]    FRAME_WIDTH_RST  = 11'd256;
	localparam logic [FDIM_W-1:0]    FRAME_HEIGHT_RST = 11'd192;
	localparam logic [ROI_W-1:0]     ROI_RST          = 16'd32;
	localparam int                   WLEN_RST         = 8;
	localparam logic [CFG_DAT_W-1:0] FIXED_AUTO       = 17'h1FFFF;
	localparam logic [PIX_W-1:0]     PIX_MAX          = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_HIGH    = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_PUSH,
		ST_CAND,
		ST_CLATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic we;
		logic restart;
		logic latch_cand;
		logic clear_cnt;
		logic cmp_valid;
		logic eval;
	} win_ctl_t;

endpackage

// ===== rtl/core/tfar_window.sv =====
// ----------------------------------------------------------------------------
// tfar_window
// rolling window memory with a rank-count compare unit for the upper median
// ----------------------------------------------------------------------------
module tfar_window #(
	parameter int LEN_LIMIT = 256,
	parameter int AW        = 8,
	parameter int LW        = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tfar_pkg::win_ctl_t       ctl,
	input  logic [AW-1:0]            waddr,
	input  logic [tfar_pkg::PIX_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	input  logic [LW-1:0]            rank,
	output logic                     done,
	output logic [tfar_pkg::PIX_W-1:0] median
);
	import tfar_pkg::*;

	logic [PIX_W-1:0] mem [LEN_LIMIT];
	logic [PIX_W-1:0] rd_q;
	logic [PIX_W-1:0] cand_q;
	logic [PIX_W-1:0] median_q;
	logic [LW-1:0]    lt_q;
	logic [LW-1:0]    le_q;
	logic             found_q;
	logic             match;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign match = (lt_q <= rank) && (rank < le_q);
	assign done  = found_q || match;
	assign median = median_q;

	always_ff @(posedge clk) begin
		if (ctl.latch_cand) begin
			cand_q <= rd_q;
		end
		if (ctl.eval && !found_q && match) begin
			median_q <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q    <= '0;
			le_q    <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctl.clear_cnt) begin
				lt_q <= '0;
				le_q <= '0;
			end else if (ctl.cmp_valid) begin
				lt_q <= lt_q + LW'(rd_q < cand_q);
				le_q <= le_q + LW'(rd_q <= cand_q);
			end
			if (ctl.restart) begin
				found_q <= 1'b0;
			end else if (ctl.eval && match) begin
				found_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/thermal_frame_auto_range_top.sv =====
// ----------------------------------------------------------------------------
// thermal_frame_auto_range_top
// per-frame statistics and rolling-median colormap range of a thermal stream
// ----------------------------------------------------------------------------
// usage
// raw 16-bit pixels enter in raster order on the s_axis channel, one transfer
// per cycle while tready is high; internal column and row counters place
// them in the frame. the last pixel of a frame produces one transfer on
// m_axis carrying the range and the frame statistics; other pixels produce
// none. with either bound automatic, frame end runs a window update: a fill
// of all entries on the first frame after reset or a window length write, a
// push of the new frame values, then an upper-median search of up to L
// candidates (L = window length), each compared against all L entries,
// shared by both windows and ending early once both medians are found, with
// tready low throughout. with both bounds fixed the window update is
// skipped. the result sits in an output register, so pixels of the next
// frame are taken while it waits; a stalled receiver only holds the block
// when the next frame has finished. reset clears counters and statistics,
// restores register defaults and marks the window empty. configuration is
// to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module thermal_frame_auto_range_top #(
	parameter int WINDOW_DEPTH = tfar_pkg::WINDOW_DEPTH_DEF,
	parameter int MAX_DIM      = tfar_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tfar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfar_pkg::CFG_DAT_W-1:0]      cfg_wr_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pixel_value
	input  logic [tfar_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// range_low, range_high, frame_minimum, frame_maximum, region_sum,
	// region_count, zero fill
	output logic [tfar_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import tfar_pkg::*;

	localparam int LEN_LIMIT = (WINDOW_DEPTH < 256) ? WINDOW_DEPTH : 256;
	localparam int AW        = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
	localparam int LW        = $clog2(LEN_LIMIT + 1);
	localparam int LEN_RESET = (WLEN_RST > LEN_LIMIT) ? LEN_LIMIT : WLEN_RST;
	localparam int DW        = $clog2(MAX_DIM + 1);
	localparam int CW        = $clog2(MAX_DIM);
	localparam int EW        = (DW > FDIM_W) ? DW : FDIM_W;

	// configuration
	logic [FDIM_W-1:0]    frame_width_q;
	logic [FDIM_W-1:0]    frame_height_q;
	logic [ROI_W-1:0]     roi_width_q;
	logic [ROI_W-1:0]     roi_height_q;
	logic [LW-1:0]        win_len_q;
	logic [CFG_DAT_W-1:0] fixed_low_q;
	logic [CFG_DAT_W-1:0] fixed_high_q;
	logic [WLEN_W-1:0]    wlen_in;
	logic [LW-1:0]        wlen_clamped;

	// frame accumulation
	logic [CW-1:0]    col_q;
	logic [CW-1:0]    row_q;
	logic [PIX_W-1:0] run_min_q;
	logic [PIX_W-1:0] run_max_q;
	logic [SUM_W-1:0] run_sum_q;
	logic [CNT_W-1:0] run_cnt_q;
	logic [PIX_W-1:0] pmin_q;
	logic [PIX_W-1:0] pmax_q;
	logic [SUM_W-1:0] psum_q;
	logic [CNT_W-1:0] pcnt_q;

	logic [DW-1:0]    w_eff;
	logic [DW-1:0]    h_eff;
	logic [DW-1:0]    rw;
	logic [DW-1:0]    rh;
	logic [DW-1:0]    rx;
	logic [DW-1:0]    ry;
	logic [PIX_W-1:0] pix;
	logic [PIX_W-1:0] new_min;
	logic [PIX_W-1:0] new_max;
	logic [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0] new_cnt;
	logic             in_roi;
	logic             line_end;
	logic             frame_end;
	logic             pix_acc;
	logic             auto_mode;

	// window sequencing
	state_t           state_q;
	state_t           state_d;
	win_ctl_t         ctl;
	logic [AW-1:0]    wp_q;
	logic             unfilled_q;
	logic [AW-1:0]    cand_idx_q;
	logic [AW-1:0]    scan_idx_q;
	logic             cmp_s1;
	logic [AW-1:0]    last_idx;
	logic [AW:0]      wp_inc;
	logic [AW-1:0]    wp_next;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [LW-1:0]    rank;
	logic             min_done;
	logic             max_done;
	logic [PIX_W-1:0] med_min;
	logic [PIX_W-1:0] med_max;

	// result
	logic [PIX_W-1:0]  sel_lo;
	logic [PIX_W-1:0]  sel_hi;
	logic [PIX_W-1:0]  ord_lo;
	logic [PIX_W-1:0]  ord_hi;
	logic [HIGH_W-1:0] fin_hi;
	logic              out_load;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	assign wlen_in = cfg_wr_data[WLEN_W-1:0];

	always_comb begin
		if (wlen_in == '0) begin
			wlen_clamped = LW'(1);
		end else if (wlen_in > WLEN_W'(LEN_LIMIT)) begin
			wlen_clamped = LW'(LEN_LIMIT);
		end else begin
			wlen_clamped = LW'(wlen_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			roi_width_q    <= ROI_RST;
			roi_height_q   <= ROI_RST;
			win_len_q      <= LW'(LEN_RESET);
			fixed_low_q    <= FIXED_AUTO;
			fixed_high_q   <= FIXED_AUTO;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q  <= cfg_wr_data[FDIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q <= cfg_wr_data[FDIM_W-1:0];
				REG_ROI_WIDTH:     roi_width_q    <= cfg_wr_data[ROI_W-1:0];
				REG_ROI_HEIGHT:    roi_height_q   <= cfg_wr_data[ROI_W-1:0];
				REG_WINDOW_LENGTH: win_len_q      <= wlen_clamped;
				REG_FIXED_LOW:     fixed_low_q    <= cfg_wr_data;
				REG_FIXED_HIGH:    fixed_high_q   <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// frame geometry and region
	// ------------------------------------------------------------------
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = DW'(1);
		end else if (EW'(frame_width_q) > EW'(MAX_DIM)) begin
			w_eff = DW'(MAX_DIM);
		end else begin
			w_eff = DW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = DW'(1);
		end else if (EW'(frame_height_q) > EW'(MAX_DIM)) begin
			h_eff = DW'(MAX_DIM);
		end else begin
			h_eff = DW'(frame_height_q);
		end
		rw = (roi_width_q < ROI_W'(w_eff)) ? DW'(roi_width_q) : w_eff;
		rh = (roi_height_q < ROI_W'(h_eff)) ? DW'(roi_height_q) : h_eff;
		if (rw == '0) begin
			rw = DW'(1);
		end
		if (rh == '0) begin
			rh = DW'(1);
		end
		rx = (w_eff - rw) >> 1;
		ry = (h_eff - rh) >> 1;
	end

	assign pix     = s_axis_tdata[PIX_W-1:0];
	assign pix_acc = s_axis_tvalid && s_axis_tready;
	assign in_roi  = (DW'(col_q) >= rx) && (DW'(col_q) < rx + rw) &&
	                 (DW'(row_q) >= ry) && (DW'(row_q) < ry + rh);
	assign new_min = (pix < run_min_q) ? pix : run_min_q;
	assign new_max = (pix > run_max_q) ? pix : run_max_q;
	assign new_sum = in_roi ? run_sum_q + SUM_W'(pix) : run_sum_q;
	assign new_cnt = in_roi ? run_cnt_q + CNT_W'(1) : run_cnt_q;
	assign line_end  = (DW'(col_q) + DW'(1)) >= w_eff;
	assign frame_end = line_end && ((DW'(row_q) + DW'(1)) >= h_eff);
	assign auto_mode = fixed_low_q[CFG_DAT_W-1] || fixed_high_q[CFG_DAT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			run_min_q <= PIX_MAX;
			run_max_q <= '0;
			run_sum_q <= '0;
			run_cnt_q <= '0;
		end else if (pix_acc) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				run_min_q <= PIX_MAX;
				run_max_q <= '0;
				run_sum_q <= '0;
				run_cnt_q <= '0;
			end else begin
				if (line_end) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				run_min_q <= new_min;
				run_max_q <= new_max;
				run_sum_q <= new_sum;
				run_cnt_q <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc && frame_end) begin
			pmin_q <= new_min;
			pmax_q <= new_max;
			psum_q <= new_sum;
			pcnt_q <= new_cnt;
		end
	end

	// ------------------------------------------------------------------
	// window sequencer
	// ------------------------------------------------------------------
	assign last_idx = AW'(win_len_q - LW'(1));
	assign wp_inc   = (AW+1)'(wp_q) + (AW+1)'(1);
	assign wp_next  = (wp_inc >= (AW+1)'(win_len_q)) ? '0 : wp_inc[AW-1:0];
	assign rank     = win_len_q >> 1;
	assign waddr    = (state_q == ST_FILL) ? cand_idx_q : wp_next;
	assign raddr    = (state_q == ST_CAND) ? cand_idx_q : scan_idx_q;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		ctl            = '0;
		ctl.cmp_valid  = cmp_s1;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_acc && frame_end) begin
					if (auto_mode) begin
						ctl.restart = 1'b1;
						state_d = unfilled_q ? ST_FILL : ST_PUSH;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FILL: begin
				ctl.we = 1'b1;
				if (cand_idx_q == last_idx) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				ctl.we  = 1'b1;
				state_d = ST_CAND;
			end
			ST_CAND: begin
				state_d = ST_CLATCH;
			end
			ST_CLATCH: begin
				ctl.latch_cand = 1'b1;
				ctl.clear_cnt  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				if ((min_done && max_done) || cand_idx_q == last_idx) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_CAND;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			unfilled_q <= 1'b1;
			cand_idx_q <= '0;
			scan_idx_q <= '0;
			cmp_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == ST_SCAN);
			if (cfg_wr_en && cfg_index == REG_WINDOW_LENGTH) begin
				wp_q       <= '0;
				unfilled_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					cand_idx_q <= '0;
				end
				ST_FILL: begin
					if (cand_idx_q == last_idx) begin
						unfilled_q <= 1'b0;
						cand_idx_q <= '0;
					end else begin
						cand_idx_q <= cand_idx_q + AW'(1);
					end
				end
				ST_PUSH: begin
					wp_q       <= wp_next;
					cand_idx_q <= '0;
				end
				ST_CLATCH: begin
					scan_idx_q <= '0;
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + AW'(1);
				end
				ST_EVAL: begin
					cand_idx_q <= cand_idx_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	tfar_window #(
		.LEN_LIMIT (LEN_LIMIT),
		.AW        (AW),
		.LW        (LW)
	) u_min_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.waddr  (waddr),
		.wdata  (pmin_q),
		.raddr  (raddr),
		.rank   (rank),
		.done   (min_done),
		.median (med_min)
	);

	tfar_window #(
		.LEN_LIMIT (LEN_LIMIT),
		.AW        (AW),
		.LW        (LW)
	) u_max_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.waddr  (waddr),
		.wdata  (pmax_q),
		.raddr  (raddr),
		.rank   (rank),
		.done   (max_done),
		.median (med_max)
	);

	// ------------------------------------------------------------------
	// range selection and output register
	// ------------------------------------------------------------------
	assign sel_lo = fixed_low_q[CFG_DAT_W-1]  ? med_min : fixed_low_q[PIX_W-1:0];
	assign sel_hi = fixed_high_q[CFG_DAT_W-1] ? med_max : fixed_high_q[PIX_W-1:0];
	assign ord_lo = (sel_lo > sel_hi) ? sel_hi : sel_lo;
	assign ord_hi = (sel_lo > sel_hi) ? sel_lo : sel_hi;
	assign fin_hi = (ord_lo == ord_hi) ? HIGH_W'(ord_lo) + HIGH_W'(1) : HIGH_W'(ord_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, pcnt_q, psum_q, pmax_q, pmin_q, fin_hi, ord_lo};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[32:16] > {1'b0, m_axis_tdata[15:0]})
		else $error("range_high not above range_low");

	a_frame_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[48:33] <= m_axis_tdata[64:49])
		else $error("frame minimum above frame maximum");

	a_len_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && cfg_index == REG_WINDOW_LENGTH) |=> (unfilled_q && wp_q == '0))
		else $error("window length write did not restart the window");

	a_median_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && cand_idx_q == last_idx) |-> (min_done && max_done))
		else $error("median search ran out of candidates");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FILL) |->
		(cand_idx_q <= last_idx && (state_q != ST_SCAN || scan_idx_q <= last_idx)))
		else $error("window index beyond window length");

endmodule

// ===== tb/tb_thermal_frame_auto_range_top.sv =====
// ----------------------------------------------------------------------------
// tb_thermal_frame_auto_range_top
// self-checking bench for the thermal frame auto-range block: a directed table
// of register writes and pixels, then random phases of frame geometry, region,
// window length and fixed bounds with random pixel content; every frame report
// is checked field by field against a fixed expectation from the table or an
// in-bench prediction of the block
module tb_thermal_frame_auto_range_top;

	import tfar_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int LEN_LIMIT = (WINDOW_DEPTH_DEF < 256) ? WINDOW_DEPTH_DEF : 256;
	localparam int PH_BACKPRESSURE = 3;
	localparam int PH_WIDE         = 5;
	localparam int PH_DEEP_WINDOW  = 7;
	localparam int PH_TALL         = 9;

	typedef struct packed {
		logic [PIX_W-1:0]  range_low;
		logic [HIGH_W-1:0] range_high;
		logic [PIX_W-1:0]  pix_min;
		logic [PIX_W-1:0]  pix_max;
		logic [SUM_W-1:0]  region_sum;
		logic [CNT_W-1:0]  region_count;
	} frame_report_t;

	typedef struct packed {
		bit                    reg_write;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DAT_W-1:0]  val;
		bit                    typed;
		frame_report_t         want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// pixel_value
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// range_low, range_high, frame_minimum, frame_maximum, region_sum,
	// region_count, zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	thermal_frame_auto_range_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// predicted register file
	logic [FDIM_W-1:0]           cfg_frame_w  = FRAME_WIDTH_RST;
	logic [FDIM_W-1:0]           cfg_frame_h  = FRAME_HEIGHT_RST;
	logic [ROI_W-1:0]            cfg_roi_w    = ROI_RST;
	logic [ROI_W-1:0]            cfg_roi_h    = ROI_RST;
	logic signed [CFG_DAT_W-1:0] cfg_fixed_lo = FIXED_AUTO;
	logic signed [CFG_DAT_W-1:0] cfg_fixed_hi = FIXED_AUTO;
	int unsigned                 win_len      = WLEN_RST;

	// predicted frame and window state
	logic [PIX_W-1:0] min_win [WINDOW_DEPTH_DEF];
	logic [PIX_W-1:0] max_win [WINDOW_DEPTH_DEF];
	int unsigned      win_pos = 0;
	bit               window_unfilled = 1'b1;
	int unsigned      col = 0;
	int unsigned      row = 0;
	logic [PIX_W-1:0] run_min = PIX_MAX;
	logic [PIX_W-1:0] run_max = '0;
	logic [36:0]      run_sum = '0;
	logic [CNT_W-1:0] run_cnt = '0;

	frame_report_t frame_reports_due [$];
	stim_row_t     directed_rows [$];
	bit            failed = 1'b0;
	int unsigned   cycle_no = 0;
	bit            hold_request = 1'b0;
	bit            hold_done = 1'b0;
	int unsigned   hold_left = 0;

	always @(posedge clk) cycle_no <= cycle_no + 1;

	function automatic bit gap_now();
		return ((cycle_no % 5000) >= 1200) && ($urandom_range(0, 99) < 36);
	endfunction

	function automatic int unsigned clamp_dim(input logic [FDIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return d;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		int unsigned n;
		case (idx)
			REG_FRAME_WIDTH: cfg_frame_w = val[FDIM_W-1:0];
			REG_FRAME_HEIGHT: cfg_frame_h = val[FDIM_W-1:0];
			REG_ROI_WIDTH: cfg_roi_w = val[ROI_W-1:0];
			REG_ROI_HEIGHT: cfg_roi_h = val[ROI_W-1:0];
			REG_WINDOW_LENGTH: begin
				n = val[WLEN_W-1:0];
				if (n == 0)
					n = 1;
				if (n > LEN_LIMIT)
					n = LEN_LIMIT;
				win_len = n;
				win_pos = 0;
				window_unfilled = 1'b1;
			end
			REG_FIXED_LOW: cfg_fixed_lo = val;
			REG_FIXED_HIGH: cfg_fixed_hi = val;
			default: ;
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] window_median(input bit of_max);
		logic [PIX_W-1:0] sorted [WINDOW_DEPTH_DEF];
		logic [PIX_W-1:0] v;
		int unsigned i, j;
		for (i = 0; i < win_len; i++) begin
			v = of_max ? max_win[i] : min_win[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[win_len / 2];
	endfunction

	// one pixel into the frame statistics; returns 1 with the report at frame end
	function automatic bit advance_frame_stats(input logic [PIX_W-1:0] v,
			output frame_report_t r);
		int unsigned w, h, rw, rh, rx, ry, lo, hi, t, i;
		bit line_end, frame_end;
		w = clamp_dim(cfg_frame_w);
		h = clamp_dim(cfg_frame_h);
		rw = (cfg_roi_w < w) ? cfg_roi_w : w;
		rh = (cfg_roi_h < h) ? cfg_roi_h : h;
		if (rw == 0)
			rw = 1;
		if (rh == 0)
			rh = 1;
		rx = (w - rw) / 2;
		ry = (h - rh) / 2;
		r = '0;
		if (v < run_min)
			run_min = v;
		if (v > run_max)
			run_max = v;
		if (col >= rx && col < rx + rw && row >= ry && row < ry + rh) begin
			run_sum = run_sum + 37'(v);
			run_cnt = run_cnt + CNT_W'(1);
		end
		line_end = (col + 1 >= w);
		frame_end = line_end && (row + 1 >= h);
		if (!frame_end) begin
			if (line_end) begin
				col = 0;
				row++;
			end else
				col++;
			return 1'b0;
		end
		lo = run_min;
		hi = run_max;
		if (cfg_fixed_lo < 0 || cfg_fixed_hi < 0) begin
			if (window_unfilled) begin
				for (i = 0; i < win_len; i++) begin
					min_win[i] = run_min;
					max_win[i] = run_max;
				end
				window_unfilled = 1'b0;
			end
			win_pos++;
			if (win_pos >= win_len)
				win_pos = 0;
			min_win[win_pos] = run_min;
			max_win[win_pos] = run_max;
			lo = window_median(1'b0);
			hi = window_median(1'b1);
		end
		if (cfg_fixed_lo >= 0)
			lo = cfg_fixed_lo;
		if (cfg_fixed_hi >= 0)
			hi = cfg_fixed_hi;
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		if (hi == lo)
			hi = lo + 1;
		r.range_low = lo[PIX_W-1:0];
		r.range_high = hi[HIGH_W-1:0];
		r.pix_min = run_min;
		r.pix_max = run_max;
		r.region_sum = run_sum[SUM_W-1:0];
		r.region_count = run_cnt;
		col = 0;
		row = 0;
		run_min = PIX_MAX;
		run_max = '0;
		run_sum = '0;
		run_cnt = '0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic void check_frame_report(input logic [OUT_TDATA_W-1:0] d);
		frame_report_t want;
		if (frame_reports_due.size() == 0) begin
			$error("frame report with none outstanding: tdata %h", d);
			failed = 1'b1;
		end else begin
			want = frame_reports_due.pop_front();
			check_field("range_low", SUM_W'(want.range_low), SUM_W'(d[15:0]));
			check_field("range_high", SUM_W'(want.range_high), SUM_W'(d[32:16]));
			check_field("frame_minimum", SUM_W'(want.pix_min), SUM_W'(d[48:33]));
			check_field("frame_maximum", SUM_W'(want.pix_max), SUM_W'(d[64:49]));
			check_field("region_sum", want.region_sum, d[100:65]);
			check_field("region_count", SUM_W'(want.region_count), SUM_W'(d[121:101]));
		end
	endfunction

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			check_frame_report(m_axis_tdata);
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 2000;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= !gap_now();
	end

	function automatic frame_report_t report(input int unsigned lo, input int unsigned hi,
			input int unsigned mn, input int unsigned mx, input int unsigned sum,
			input int unsigned cnt);
		frame_report_t r;
		r.range_low = lo[PIX_W-1:0];
		r.range_high = hi[HIGH_W-1:0];
		r.pix_min = mn[PIX_W-1:0];
		r.pix_max = mx[PIX_W-1:0];
		r.region_sum = SUM_W'(sum);
		r.region_count = cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic void put_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.reg_write = 1'b1;
		r.idx = idx;
		r.val = val;
		directed_rows.push_back(r);
	endfunction

	function automatic void put_pixel(input logic [PIX_W-1:0] v);
		stim_row_t r;
		r = '0;
		r.idx = REG_NONE;
		r.val = CFG_DAT_W'(v);
		directed_rows.push_back(r);
	endfunction

	function automatic void put_checked_pixel(input logic [PIX_W-1:0] v,
			input frame_report_t want);
		stim_row_t r;
		r = '0;
		r.idx = REG_NONE;
		r.val = CFG_DAT_W'(v);
		r.typed = 1'b1;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [CFG_DAT_W-1:0] pick_bound();
		logic [CFG_DAT_W-1:0] b;
		int unsigned sel;
		b = CFG_DAT_W'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 5)
			b = FIXED_AUTO;
		else
			b[CFG_DAT_W-1] = (sel < 7);
		return b;
	endfunction

	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		while (frame_reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		apply_reg_write(idx, val);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] v, input bit typed,
			input frame_report_t want);
		frame_report_t got;
		bit ends;
		cfg_wr_en <= 1'b0;
		while (gap_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ends = advance_frame_stats(v, got);
		if (typed)
			frame_reports_due.push_back(want);
		else if (ends)
			frame_reports_due.push_back(got);
	endtask

	initial begin : stimulus
		int unsigned phase_no, random_pixels, fw, fh, frames, n_pix, mode, i;
		logic [CFG_DAT_W-1:0] r17, lo_val;
		logic [PIX_W-1:0] px, base;
		frame_report_t none;
		none = '0;

		// single pixel frames first: extremes, fixed bounds, window restarts
		put_reg(REG_FRAME_WIDTH, 17'd1);
		put_reg(REG_FRAME_HEIGHT, 17'd1);
		put_checked_pixel(16'd0, report(0, 1, 0, 0, 0, 1));
		put_pixel(16'hFFFF);
		put_pixel(16'hFFFF);
		put_reg(REG_NONE, 17'h1ABCD);
		put_reg(REG_FIXED_LOW, 17'd65535);
		put_reg(REG_FIXED_HIGH, 17'd65535);
		put_checked_pixel(16'd1234, report(65535, 65536, 1234, 1234, 1234, 1));
		put_reg(REG_FIXED_LOW, 17'd0);
		put_reg(REG_FIXED_HIGH, 17'd0);
		put_checked_pixel(16'd0, report(0, 1, 0, 0, 0, 1));
		put_reg(REG_FIXED_LOW, 17'd300);
		put_reg(REG_FIXED_HIGH, 17'd200);
		put_checked_pixel(16'd7, report(200, 300, 7, 7, 7, 1));
		put_reg(REG_FIXED_LOW, FIXED_AUTO);
		put_reg(REG_FIXED_HIGH, 17'd500);
		put_pixel(16'd9);
		put_reg(REG_FIXED_LOW, 17'd40);
		put_reg(REG_FIXED_HIGH, 17'h10000);
		put_pixel(16'hFFFF);
		put_reg(REG_FIXED_LOW, FIXED_AUTO);
		put_reg(REG_FIXED_HIGH, FIXED_AUTO);
		put_reg(REG_WINDOW_LENGTH, 17'd0);
		put_checked_pixel(16'd77, report(77, 78, 77, 77, 77, 1));
		put_reg(REG_WINDOW_LENGTH, 17'd300);
		put_checked_pixel(16'd5, report(5, 6, 5, 5, 5, 1));
		put_pixel(16'd6);
		put_reg(REG_WINDOW_LENGTH, 17'd2);
		put_reg(REG_FRAME_WIDTH, 17'd0);
		put_reg(REG_FRAME_HEIGHT, 17'd0);
		put_checked_pixel(16'd100, report(100, 101, 100, 100, 100, 1));
		// region clamped to the frame, zero height acting as one line
		put_reg(REG_FRAME_WIDTH, 17'd3);
		put_reg(REG_FRAME_HEIGHT, 17'd2);
		put_reg(REG_ROI_WIDTH, 17'd65535);
		put_reg(REG_ROI_HEIGHT, 17'd0);
		for (i = 1; i <= 6; i++)
			put_pixel(PIX_W'(i));
		// width shrinks in the middle of a frame
		put_pixel(16'd10);
		put_pixel(16'd20);
		put_reg(REG_FRAME_WIDTH, 17'd1);
		put_pixel(16'd30);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].reg_write) begin
				wait_for_idle();
				write_reg(directed_rows[k].idx, directed_rows[k].val);
			end else
				send_pixel(directed_rows[k].val[PIX_W-1:0], directed_rows[k].typed,
					directed_rows[k].want);
		end

		phase_no = 0;
		random_pixels = 0;
		while (random_pixels < 1500 || phase_no < PH_TALL) begin
			wait_for_idle();
			phase_no++;
			frames = $urandom_range(1, 6);
			if (phase_no == PH_BACKPRESSURE) begin
				fw = 2;
				fh = 1;
				frames = 10;
			end else if (phase_no == PH_WIDE) begin
				fw = 2047;
				fh = 1;
				frames = 1;
			end else if (phase_no == PH_DEEP_WINDOW) begin
				fw = 1;
				fh = 1;
				frames = 2;
			end else if (phase_no == PH_TALL) begin
				fw = 1;
				fh = 200;
				frames = 1;
			end else begin
				fw = $urandom_range(0, 9);
				fh = $urandom_range(0, 8);
			end
			r17 = CFG_DAT_W'($urandom);
			r17[FDIM_W-1:0] = FDIM_W'(fw);
			write_reg(REG_FRAME_WIDTH, r17);
			r17 = CFG_DAT_W'($urandom);
			r17[FDIM_W-1:0] = FDIM_W'(fh);
			write_reg(REG_FRAME_HEIGHT, r17);
			for (i = 0; i < 2; i++) begin
				r17 = CFG_DAT_W'($urandom);
				mode = $urandom_range(0, 3);
				if (mode == 1)
					r17[ROI_W-1:0] = '0;
				else if (mode > 1)
					r17[ROI_W-1:0] = ROI_W'($urandom_range(1, 10));
				write_reg(i == 0 ? REG_ROI_WIDTH : REG_ROI_HEIGHT, r17);
			end
			r17 = CFG_DAT_W'($urandom);
			if (phase_no == PH_DEEP_WINDOW) begin
				r17[WLEN_W-1:0] = WLEN_W'(32'h100 | $urandom_range(0, 255));
				write_reg(REG_WINDOW_LENGTH, r17);
			end else if (win_len > 16 || $urandom_range(0, 1)) begin
				r17[WLEN_W-1:0] = WLEN_W'($urandom_range(0, 12));
				write_reg(REG_WINDOW_LENGTH, r17);
			end
			lo_val = pick_bound();
			if (phase_no == PH_DEEP_WINDOW)
				lo_val = FIXED_AUTO;
			write_reg(REG_FIXED_LOW, lo_val);
			write_reg(REG_FIXED_HIGH, pick_bound());

			n_pix = frames * clamp_dim(FDIM_W'(fw)) * clamp_dim(FDIM_W'(fh));
			if (phase_no != PH_DEEP_WINDOW && phase_no != PH_BACKPRESSURE &&
					phase_no != PH_WIDE && phase_no != PH_TALL &&
					$urandom_range(0, 3) == 0)
				n_pix = n_pix + $urandom_range(0,
					clamp_dim(FDIM_W'(fw)) * clamp_dim(FDIM_W'(fh)) - 1);
			random_pixels = random_pixels + n_pix;
			if (phase_no == PH_BACKPRESSURE)
				hold_request = 1'b1;
			mode = $urandom_range(0, 2);
			base = PIX_W'($urandom);
			for (i = 0; i < n_pix; i++) begin
				if (mode == 0)
					px = PIX_W'($urandom);
				else if (mode == 1)
					px = base + PIX_W'($urandom_range(0, 7));
				else
					px = $urandom_range(0, 1) ? PIX_MAX : '0;
				send_pixel(px, 1'b0, none);
			end
		end

		wait_for_idle();
		repeat (win_len * (win_len + 4) + win_len + 16) @(posedge clk);
		if (failed)
			$display("RESULT: ERROR");
		else
			$display("RESULT: OK");
		$finish;
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tfar_pkg.sv
rtl/core/tfar_window.sv
rtl/core/thermal_frame_auto_range_top.sv
tb/tb_thermal_frame_auto_range_top.sv
